>>> rtl/xad_pkg.sv
`timescale 1ns / 1ps
package xad_pkg;

    localparam int SECTOR_BYTES      = 2336;
    localparam int GROUPS_PER_SECTOR = 18;
    localparam int GROUP_BYTES       = 128;
    localparam int SUBHDR_BYTES      = 8;
    localparam int HDR_FIRST         = 4;    // sub-block headers at group offsets 4..11
    localparam int NUM_SUBBLOCKS     = 8;
    localparam int NIB_BASE          = 16;   // first sample byte inside a group
    localparam int SB_SAMPLES        = 28;
    localparam int GROUP_SAMPLES     = 224;
    localparam int SLOTS             = 4;    // samples per result word

    localparam int POS_W   = 12;
    localparam int OFF_W   = $clog2(GROUP_BYTES);
    localparam int GRP_W   = POS_W - OFF_W;
    localparam int SB_W    = $clog2(NUM_SUBBLOCKS);
    localparam int W_W     = $clog2(SB_SAMPLES);
    localparam int K_W     = $clog2(GROUP_SAMPLES);
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int HIST_W  = 32;
    localparam int COEF_W  = 8;
    localparam int PROD_W  = HIST_W + COEF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SMP_W   = 16;
    localparam int PRED_SH = 6;
    localparam int PRED_RND = 32;

    localparam logic signed [HIST_W-1:0] SMP_MAX = 32'sd32767;
    localparam logic signed [HIST_W-1:0] SMP_MIN = -32'sd32768;

    typedef enum logic [0:0] {
        CFG_MATCH_FILE    = 1'b0,
        CFG_MATCH_CHANNEL = 1'b1
    } t_cfg_idx;

    // Store writes and group commands from the sector parser to the decoder
    typedef struct packed {
        logic             we;
        logic [OFF_W-1:0] addr;
        logic [7:0]       data;
        logic             hdr_we;
        logic             start;
        logic             last_group;
        logic             stereo;
        logic             clear;
    } t_grp_wr;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_a;
        logic signed [SMP_W-1:0] sample_b;
        logic signed [SMP_W-1:0] sample_c;
        logic signed [SMP_W-1:0] sample_d;
        logic                    stereo_layout;
        logic                    group_last;
        logic                    sector_last;
    } t_result;

    function automatic logic signed [COEF_W-1:0] coef_pos(input logic [2:0] filt);
        logic signed [COEF_W-1:0] c;
        case (filt)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_neg(input logic [2:0] filt);
        logic signed [COEF_W-1:0] c;
        case (filt)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/xa_adpcm_sector_decoder_top.sv
`timescale 1ns / 1ps
// XA 4-bit ADPCM sector decoder. Feed a raw 2336-byte XA sector one word per
// byte, starting at the subheader, with sector_begin on its first byte. A
// sector is decoded only if its subheader file and channel equal the
// match_file and match_channel registers and its coding byte marks 4-bit
// audio; all other sectors are swallowed silently. Each 128-byte sound group
// is collected in a group store; its last byte starts the decoder, which
// produces 56 result words of four 16-bit samples (L,R,L,R in stereo, four
// consecutive samples in mono), flagging the last word of each group and of
// the eighteenth group. Bytes that do not close a group are taken as offered.
// After the byte that closes a decoded group, i_valid is not taken while the
// decoder loads both channels' predictor history from the history RAM, runs
// each of the 224 samples through a store read plus multiply step and then
// an accumulate, clamp and history update step (the next sample depending on
// this one's result), and writes the history back; a stalled result word
// adds its stall. Configuration is written through a plain write port and
// must be changed only while idle; the match is decided on the sector's
// fourth byte.
module xa_adpcm_sector_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_sector_byte,
    input  logic        i_sector_begin,
    input  logic        i_clear_history,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_sample_a,
    output logic signed [15:0] o_sample_b,
    output logic signed [15:0] o_sample_c,
    output logic signed [15:0] o_sample_d,
    output logic        o_stereo_layout,
    output logic        o_group_last,
    output logic        o_sector_last,
    // configuration
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import xad_pkg::*;

    logic [7:0]       r_match_file, r_match_channel;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_sub_file, r_sub_channel, r_coding;
    logic             r_taken;

    logic             w_acc;
    logic             w_idle;
    logic [POS_W-1:0] w_pos, w_rel;
    logic             w_taken;
    logic [GRP_W-1:0] w_grp;
    logic [OFF_W-1:0] w_off;
    logic             w_in_grp;
    t_grp_wr          w_gw;
    t_result          w_res;

    assign o_ready = w_idle;
    assign w_acc   = i_valid && w_idle;

    // sector_begin restarts the count before this byte is handled
    assign w_pos   = i_sector_begin ? '0 : r_pos;
    assign w_taken = i_sector_begin ? 1'b0 : r_taken;
    assign w_rel   = w_pos - POS_W'(SUBHDR_BYTES);
    assign w_grp   = w_rel[POS_W-1:OFF_W];
    assign w_off   = w_rel[OFF_W-1:0];

    assign w_in_grp = (w_pos >= POS_W'(SUBHDR_BYTES)) && (w_pos < POS_W'(SECTOR_BYTES))
                   && w_taken && (w_grp < GRP_W'(GROUPS_PER_SECTOR));

    always_comb begin
        w_gw.we         = w_acc && w_in_grp;
        w_gw.addr       = w_off;
        w_gw.data       = i_sector_byte;
        w_gw.hdr_we     = w_gw.we && (w_off >= OFF_W'(HDR_FIRST))
                       && (w_off < OFF_W'(HDR_FIRST + NUM_SUBBLOCKS));
        w_gw.start      = w_gw.we && (w_off == OFF_W'(GROUP_BYTES - 1));
        w_gw.last_group = (w_grp == GRP_W'(GROUPS_PER_SECTOR - 1));
        w_gw.stereo     = r_coding[0];
        w_gw.clear      = w_acc && i_clear_history;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_file    <= '0;
            r_match_channel <= '0;
            r_pos           <= '0;
            r_sub_file      <= '0;
            r_sub_channel   <= '0;
            r_coding        <= '0;
            r_taken         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MATCH_FILE:    r_match_file    <= i_cfg_data;
                    CFG_MATCH_CHANNEL: r_match_channel <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_taken <= w_taken;
                // hold the count once a sector runs past its length
                if (w_pos < POS_W'(SECTOR_BYTES)) begin
                    r_pos <= w_pos + 1'b1;
                    case (w_pos)
                        POS_W'(0): begin
                            r_sub_file <= i_sector_byte;
                            r_taken    <= 1'b0;
                        end
                        POS_W'(1): r_sub_channel <= i_sector_byte;
                        POS_W'(3): begin
                            r_coding <= i_sector_byte;
                            r_taken  <= (r_sub_file == r_match_file)
                                     && (r_sub_channel == r_match_channel)
                                     && !i_sector_byte[4];
                        end
                        default: ;
                    endcase
                end else begin
                    r_pos <= w_pos;
                end
            end
        end
    end

    xad_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (w_gw),
        .o_idle      (w_idle),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_res       (w_res)
    );

    assign o_sample_a      = w_res.sample_a;
    assign o_sample_b      = w_res.sample_b;
    assign o_sample_c      = w_res.sample_c;
    assign o_sample_d      = w_res.sample_d;
    assign o_stereo_layout = w_res.stereo_layout;
    assign o_group_last    = w_res.group_last;
    assign o_sector_last   = w_res.sector_last;
endmodule

>>> rtl/xad_ram.sv
`timescale 1ns / 1ps
module xad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/xad_dec.sv
`timescale 1ns / 1ps
module xad_dec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xad_pkg::t_grp_wr i_grp,
    output logic             o_idle,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output xad_pkg::t_result o_res
);
    import xad_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LD0  = 8'b0000_0010,
        ST_LD1  = 8'b0000_0100,
        ST_LD2  = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_ADD  = 8'b0010_0000,
        ST_WB0  = 8'b0100_0000,
        ST_WB1  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [SB_W-1:0]  r_sb, n_sb;
    logic [W_W-1:0]   r_w, n_w;
    logic [K_W-1:0]   r_k;
    logic             r_stereo;
    logic             r_last_grp;
    logic [1:0]       r_hv;
    logic [7:0]       r_hdr [NUM_SUBBLOCKS];
    logic signed [HIST_W-1:0] r_hl0, r_hl1, r_hr0, r_hr1;
    logic signed [PROD_W-1:0] r_p0, r_p1;
    logic signed [SMP_W-1:0]  r_base;
    logic signed [SMP_W-1:0]  r_s0, r_s1, r_s2;
    logic             r_o_valid;
    t_result          r_o;

    logic [OFF_W-1:0] w_st_raddr;
    logic [7:0]       w_st_rdata;
    logic             w_hist_we;
    logic             w_hist_waddr;
    logic             w_hist_raddr;
    logic [2*HIST_W-1:0] w_hist_wdata, w_hist_rdata;
    logic signed [HIST_W-1:0] w_hrd0, w_hrd1;

    logic [7:0]       w_hdr;
    logic [3:0]       w_nib;
    logic             w_ch;
    logic signed [HIST_W-1:0] w_h0, w_h1;
    logic signed [SMP_W-1:0]  w_nib16;
    logic signed [SUM_W-1:0]  w_psum, w_tot;
    logic signed [HIST_W-1:0] w_s;
    logic signed [SMP_W-1:0]  w_clamp;
    logic [SLOT_W-1:0] w_slot;
    logic             w_stall, w_commit, w_k_last;
    logic [SB_W-1:0]  w_hidx;

    // group store: written from the byte stream, read one sample byte per sample
    xad_ram #(.WIDTH(8), .DEPTH(GROUP_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_grp.we),
        .i_waddr (i_grp.addr),
        .i_wdata (i_grp.data),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    // predictor history: one entry per channel, {newer, older}
    xad_ram #(.WIDTH(2*HIST_W), .DEPTH(2)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rdata)
    );

    assign w_hidx = SB_W'(i_grp.addr - OFF_W'(HDR_FIRST));

    assign w_slot   = r_k[SLOT_W-1:0];
    assign w_k_last = (r_k == K_W'(GROUP_SAMPLES - 1));
    assign w_stall  = (w_slot == SLOT_W'(SLOTS - 1)) && r_o_valid && !i_res_ready;
    assign w_commit = (r_state == ST_ADD) && !w_stall;

    // sample counters; the store address follows the next value
    always_comb begin
        n_sb = r_sb;
        n_w  = r_w;
        if (r_state == ST_IDLE && i_grp.start) begin
            n_sb = '0;
            n_w  = '0;
        end else if (w_commit) begin
            if (r_stereo) begin
                if (!r_sb[0]) begin
                    n_sb[0] = 1'b1;
                end else begin
                    n_sb[0] = 1'b0;
                    if (r_w == W_W'(SB_SAMPLES - 1)) begin
                        n_w = '0;
                        n_sb[SB_W-1:1] = r_sb[SB_W-1:1] + 1'b1;
                    end else begin
                        n_w = r_w + 1'b1;
                    end
                end
            end else begin
                if (r_w == W_W'(SB_SAMPLES - 1)) begin
                    n_w  = '0;
                    n_sb = r_sb + 1'b1;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
        end
    end

    assign w_st_raddr = OFF_W'(NIB_BASE) + {n_w, n_sb[SB_W-1:1]};

    assign w_hist_raddr = (r_state == ST_LD1);
    assign w_hist_we    = (r_state == ST_WB0) || (r_state == ST_WB1);
    assign w_hist_waddr = (r_state == ST_WB1);
    assign w_hist_wdata = (r_state == ST_WB1) ? {r_hr0, r_hr1} : {r_hl0, r_hl1};
    assign w_hrd0 = w_hist_rdata[2*HIST_W-1:HIST_W];
    assign w_hrd1 = w_hist_rdata[HIST_W-1:0];

    assign w_hdr   = r_hdr[r_sb];
    assign w_nib   = r_sb[0] ? w_st_rdata[7:4] : w_st_rdata[3:0];
    assign w_ch    = r_stereo & r_sb[0];
    assign w_h0    = w_ch ? r_hr0 : r_hl0;
    assign w_h1    = w_ch ? r_hr1 : r_hl1;
    assign w_nib16 = {w_nib, 12'd0};

    assign w_psum = SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(PRED_RND);
    assign w_tot  = (w_psum >>> PRED_SH) + SUM_W'(r_base);
    assign w_s    = w_tot[HIST_W-1:0];

    always_comb begin
        if (w_s > SMP_MAX) begin
            w_clamp = SMP_MAX[SMP_W-1:0];
        end else if (w_s < SMP_MIN) begin
            w_clamp = SMP_MIN[SMP_W-1:0];
        end else begin
            w_clamp = w_s[SMP_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_grp.start) n_state = ST_LD0;
            ST_LD0:  n_state = ST_LD1;
            ST_LD1:  n_state = ST_LD2;
            ST_LD2:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD: begin
                if (w_commit) n_state = w_k_last ? ST_WB0 : ST_MUL;
            end
            ST_WB0:  n_state = ST_WB1;
            ST_WB1:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hv      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_grp.clear) begin
                r_hv <= '0;
            end else if (r_state == ST_WB0) begin
                r_hv[0] <= 1'b1;
            end else if (r_state == ST_WB1) begin
                r_hv[1] <= 1'b1;
            end
            if (w_commit && w_slot == SLOT_W'(SLOTS - 1)) begin
                r_o_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb <= n_sb;
        r_w  <= n_w;
        if (i_grp.hdr_we) begin
            r_hdr[w_hidx] <= i_grp.data;
        end
        if (r_state == ST_IDLE && i_grp.start) begin
            r_k        <= '0;
            r_stereo   <= i_grp.stereo;
            r_last_grp <= i_grp.last_group;
        end
        // load history; an entry cleared since its last write reads as zero
        if (r_state == ST_LD1) begin
            r_hl0 <= r_hv[0] ? w_hrd0 : '0;
            r_hl1 <= r_hv[0] ? w_hrd1 : '0;
        end
        if (r_state == ST_LD2) begin
            r_hr0 <= r_hv[1] ? w_hrd0 : '0;
            r_hr1 <= r_hv[1] ? w_hrd1 : '0;
        end
        if (r_state == ST_MUL) begin
            r_p0   <= w_h0 * coef_pos(w_hdr[6:4]);
            r_p1   <= w_h1 * coef_neg(w_hdr[6:4]);
            r_base <= w_nib16 >>> w_hdr[3:0];
        end
        if (w_commit) begin
            r_k <= r_k + 1'b1;
            if (w_ch) begin
                r_hr1 <= r_hr0;
                r_hr0 <= w_s;
            end else begin
                r_hl1 <= r_hl0;
                r_hl0 <= w_s;
            end
            case (w_slot)
                2'd0: r_s0 <= w_clamp;
                2'd1: r_s1 <= w_clamp;
                2'd2: r_s2 <= w_clamp;
                default: begin
                    r_o.sample_a      <= r_s0;
                    r_o.sample_b      <= r_s1;
                    r_o.sample_c      <= r_s2;
                    r_o.sample_d      <= w_clamp;
                    r_o.stereo_layout <= r_stereo;
                    r_o.group_last    <= w_k_last;
                    r_o.sector_last   <= w_k_last && r_last_grp;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = r_o_valid;
    assign o_res       = r_o;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_grp.start |-> r_state == ST_IDLE)
        else $error("group start while decoder busy");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_grp.clear |-> r_state == ST_IDLE)
        else $error("history clear while decoder busy");

    a_word_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == ST_ADD)
        else $error("result word raised outside sample commit");

    a_sector_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o.sector_last |-> r_o.group_last)
        else $error("sector end flagged off a group end");

    a_hist_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WB1 |=> r_hv == 2'b11)
        else $error("history write-back left an entry invalid");
endmodule

>>> verif/xa_adpcm_sector_decoder_top_tb.sv
`timescale 1ns / 1ps
module xa_adpcm_sector_decoder_top_tb;
    import xad_pkg::*;

    localparam int HOLD_CYCLES  = 1500;   // long output stall for the pressure test
    localparam int DRAIN_CYCLES = 40;     // history write-back plus margin
    localparam int MAX_REPORTS  = 10;

    typedef enum int {
        GRP_RANDOM,
        GRP_MIXED
    } t_group_kind;

    // DUT ports
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    logic [7:0]         i_sector_byte   = 8'h00;
    logic               i_sector_begin  = 1'b0;
    logic               i_clear_history = 1'b0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    logic signed [15:0] o_sample_a;
    logic signed [15:0] o_sample_b;
    logic signed [15:0] o_sample_c;
    logic signed [15:0] o_sample_d;
    logic               o_stereo_layout;
    logic               o_group_last;
    logic               o_sector_last;
    logic               i_cfg_we        = 1'b0;
    logic [0:0]         i_cfg_index     = '0;
    logic [7:0]         i_cfg_data      = 8'h00;

    // Pacing knobs, percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_active  = 1'b0;
    event hold_start;

    // Decoder state as the block should hold it
    logic [7:0]  mdl_match_file;
    logic [7:0]  mdl_match_channel;
    int unsigned mdl_pos;
    logic [7:0]  mdl_file;
    logic [7:0]  mdl_channel;
    logic [7:0]  mdl_coding;
    logic        mdl_taken;
    logic [7:0]  mdl_group [GROUP_BYTES];
    int          mdl_hist [4];
    logic signed [15:0] left_smp  [SB_SAMPLES];
    logic signed [15:0] right_smp [SB_SAMPLES];

    t_result    pending_words [$];
    logic [7:0] sect_img [$];

    int error_count   = 0;
    int bytes_sent    = 0;
    int words_seen    = 0;
    int groups_seen   = 0;
    int sectors_seen  = 0;

    xa_adpcm_sector_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sector_byte   (i_sector_byte),
        .i_sector_begin  (i_sector_begin),
        .i_clear_history (i_clear_history),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_a      (o_sample_a),
        .o_sample_b      (o_sample_b),
        .o_sample_c      (o_sample_c),
        .o_sample_d      (o_sample_d),
        .o_stereo_layout (o_stereo_layout),
        .o_group_last    (o_group_last),
        .o_sector_last   (o_sector_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decode prediction
    // ------------------------------------------------------------------

    // Filter gains, scaled by 64
    function automatic void filter_weights(input logic [2:0] filt, output int wp, output int wn);
        case (filt)
            3'd1: begin wp = 60;  wn = 0;   end
            3'd2: begin wp = 115; wn = -52; end
            3'd3: begin wp = 98;  wn = -55; end
            3'd4: begin wp = 122; wn = -60; end
            default: begin wp = 0; wn = 0; end
        endcase
    endfunction

    function automatic logic signed [15:0] clamp_sample(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Run one sub-block through the predictor; hb selects the history pair.
    function automatic void run_subblock(input int sb, input int hb, input bit to_right);
        logic [7:0] hdr;
        logic [7:0] sbyte;
        logic [3:0] nib;
        int         shift;
        int         wp;
        int         wn;
        int         w;
        int         wrapped;
        longint     base;
        longint     pred;
        longint     total;
        hdr   = mdl_group[HDR_FIRST + sb];
        shift = hdr[3:0];
        filter_weights(hdr[6:4], wp, wn);
        for (w = 0; w < SB_SAMPLES; w++) begin
            sbyte = mdl_group[NIB_BASE + 4 * w + (sb >> 1)];
            nib   = sb[0] ? sbyte[7:4] : sbyte[3:0];
            base  = longint'($signed(nib)) * 4096;
            pred  = longint'(mdl_hist[hb]) * wp + longint'(mdl_hist[hb + 1]) * wn + 32;
            total = (base >>> shift) + (pred >>> 6);
            // history keeps the full 32-bit wrapped value, only the output clamps
            wrapped = total[31:0];
            mdl_hist[hb + 1] = mdl_hist[hb];
            mdl_hist[hb]     = wrapped;
            if (to_right)
                right_smp[w] = clamp_sample(wrapped);
            else
                left_smp[w] = clamp_sample(wrapped);
        end
    endfunction

    function automatic void queue_group_words(input bit last_group);
        t_result wd;
        int      n;
        int      p;
        int      s;
        n = 0;
        if (mdl_coding[0]) begin
            for (p = 0; p < NUM_SUBBLOCKS / 2; p++) begin
                run_subblock(2 * p, 0, 1'b0);
                run_subblock(2 * p + 1, 2, 1'b1);
                for (s = 0; s < SB_SAMPLES; s += 2) begin
                    wd.sample_a      = left_smp[s];
                    wd.sample_b      = right_smp[s];
                    wd.sample_c      = left_smp[s + 1];
                    wd.sample_d      = right_smp[s + 1];
                    wd.stereo_layout = 1'b1;
                    wd.group_last    = (n == 55);
                    wd.sector_last   = (n == 55) && last_group;
                    pending_words.push_back(wd);
                    n++;
                end
            end
        end else begin
            for (p = 0; p < NUM_SUBBLOCKS; p++) begin
                run_subblock(p, 0, 1'b0);
                for (s = 0; s < SB_SAMPLES; s += 4) begin
                    wd.sample_a      = left_smp[s];
                    wd.sample_b      = left_smp[s + 1];
                    wd.sample_c      = left_smp[s + 2];
                    wd.sample_d      = left_smp[s + 3];
                    wd.stereo_layout = 1'b0;
                    wd.group_last    = (n == 55);
                    wd.sector_last   = (n == 55) && last_group;
                    pending_words.push_back(wd);
                    n++;
                end
            end
        end
    endfunction

    // Advance the expected decoder state by one accepted byte.
    function automatic void track_byte(input logic [7:0] value, input logic first,
                                       input logic clr);
        int unsigned pos;
        int unsigned rel;
        int unsigned grp;
        int unsigned off;
        if (clr)
            foreach (mdl_hist[i]) mdl_hist[i] = 0;
        if (first) begin
            mdl_pos   = 0;
            mdl_taken = 1'b0;
        end
        pos = mdl_pos;
        if (pos >= SECTOR_BYTES)
            return;
        mdl_pos = pos + 1;
        if (pos == 0) begin
            mdl_file  = value;
            mdl_taken = 1'b0;
            return;
        end
        if (pos == 1) begin
            mdl_channel = value;
            return;
        end
        if (pos == 3) begin
            mdl_coding = value;
            mdl_taken  = (mdl_file == mdl_match_file) && (mdl_channel == mdl_match_channel)
                         && !value[4];
            return;
        end
        if (pos < SUBHDR_BYTES || !mdl_taken)
            return;
        rel = pos - SUBHDR_BYTES;
        grp = rel / GROUP_BYTES;
        off = rel % GROUP_BYTES;
        if (grp >= GROUPS_PER_SECTOR)
            return;
        mdl_group[off] = value;
        if (off == GROUP_BYTES - 1)
            queue_group_words(grp == GROUPS_PER_SECTOR - 1);
    endfunction

    // ------------------------------------------------------------------
    // Output side: pace i_ready, check every accepted word
    // ------------------------------------------------------------------

    // Stall the output for a fixed stretch when asked
    always begin
        @(hold_start);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_active)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    always @(posedge i_clk) begin : check_words
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.sample_a      = o_sample_a;
            got.sample_b      = o_sample_b;
            got.sample_c      = o_sample_c;
            got.sample_d      = o_sample_d;
            got.stereo_layout = o_stereo_layout;
            got.group_last    = o_group_last;
            got.sector_last   = o_sector_last;
            words_seen++;
            if (o_group_last)
                groups_seen++;
            if (o_sector_last)
                sectors_seen++;
            if (pending_words.size() == 0) begin
                flag_error($sformatf("unexpected word %0d: %0d %0d %0d %0d st=%0b gl=%0b sl=%0b",
                    words_seen, got.sample_a, got.sample_b, got.sample_c, got.sample_d,
                    got.stereo_layout, got.group_last, got.sector_last));
            end else begin
                want = pending_words.pop_front();
                if (got !== want)
                    flag_error({$sformatf("word %0d expected %0d %0d %0d %0d st=%0b gl=%0b sl=%0b",
                        words_seen, want.sample_a, want.sample_b, want.sample_c,
                        want.sample_d, want.stereo_layout, want.group_last, want.sector_last),
                        $sformatf(" got %0d %0d %0d %0d st=%0b gl=%0b sl=%0b",
                        got.sample_a, got.sample_b, got.sample_c, got.sample_d,
                        got.stereo_layout, got.group_last, got.sector_last)});
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    task automatic set_pacing(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Offer one byte, hold it until taken, then advance the expected state.
    task automatic push_byte(input logic [7:0] value, input logic first, input logic clr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sector_byte   <= value;
        i_sector_begin  <= first;
        i_clear_history <= clr;
        do @(posedge i_clk); while (!o_ready);
        track_byte(value, first, clr);
        bytes_sent++;
    endtask

    // Send sect_img[lo..hi-1]; index 0 carries sector_begin when mark_begin is set.
    task automatic send_span(input int lo, input int hi, input bit mark_begin, input int clear_at);
        int  i;
        for (i = lo; i < hi; i++)
            push_byte(sect_img[i], mark_begin && (i == 0), i == clear_at);
    endtask

    // Drop valid, drain all expected words, then let the decoder settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_MATCH_FILE)
            mdl_match_file = value;
        else
            mdl_match_channel = value;
    endtask

    task automatic add_group(input t_group_kind kind);
        logic [7:0] b;
        int         off;
        int         sb;
        for (off = 0; off < GROUP_BYTES; off++) begin
            b  = 8'($urandom_range(255));
            sb = off - HDR_FIRST;
            if (off >= HDR_FIRST && off < HDR_FIRST + NUM_SUBBLOCKS) begin
                if (kind == GRP_MIXED && sb < 4) begin
                    // strongest filter, no shift: drive the clamp both ways
                    b = {b[7], 3'd4, 4'd0};
                end else if ($urandom_range(3) != 0) begin
                    // keep most shifts in the useful range
                    b[3:0] = 4'($urandom_range(12));
                end
            end else if (kind == GRP_MIXED && off >= NIB_BASE) begin
                case ((off - NIB_BASE) % 4)
                    0: b = 8'h77;
                    1: b = 8'h88;
                    default: ;
                endcase
            end
            sect_img.push_back(b);
        end
    endtask

    task automatic build_sector(input logic [7:0] file, input logic [7:0] chan,
                                input logic [7:0] coding, input int ngroups);
        sect_img.delete();
        sect_img.push_back(file);
        sect_img.push_back(chan);
        sect_img.push_back(8'($urandom_range(255)));
        sect_img.push_back(coding);
        repeat (4) sect_img.push_back(8'($urandom_range(255)));
        repeat (ngroups) add_group(GRP_RANDOM);
    endtask

    task automatic add_noise(input int count);
        repeat (count) sect_img.push_back(8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes before any sector_begin count from position zero; reset match is 0/0.
    // One stereo group with saturating sub-blocks and random filters. The
    // receiver holds off long enough that the decoder backs up into the input
    // while more bytes are offered.
    task automatic test_decode_group();
        set_pacing(0, 74);
        -> hold_start;
        build_sector(8'h00, 8'h00, 8'h01, 0);
        add_group(GRP_MIXED);
        add_noise(4);
        send_span(0, sect_img.size(), 1'b0, -1);
        wait_idle();
    endtask

    // Wrong file, wrong channel and 8-bit sectors are swallowed.
    task automatic test_rejects();
        set_pacing(74, 0);
        write_reg(CFG_MATCH_FILE, 8'h5A);
        write_reg(CFG_MATCH_CHANNEL, 8'hA5);
        build_sector(8'h5B, 8'hA5, 8'h00, 0);
        add_noise(1);
        send_span(0, sect_img.size(), 1'b1, -1);
        build_sector(8'h5A, 8'h25, 8'h01, 0);
        add_noise(1);
        send_span(0, sect_img.size(), 1'b1, -1);
        build_sector(8'h5A, 8'hA5, 8'h10, 0);
        add_noise(1);
        send_span(0, sect_img.size(), 1'b1, -1);
        wait_idle();
    endtask

    // Restart inside the subheader, then a full subheader.
    task automatic test_restart();
        set_pacing(7, 7);
        build_sector(8'h5A, 8'hA5, 8'h01, 0);
        send_span(0, 2, 1'b1, -1);
        build_sector(8'h5A, 8'hA5, 8'h00, 0);
        send_span(0, sect_img.size(), 1'b1, -1);
        wait_idle();
    endtask

    // Back-to-back bytes with a history clear on the sector_begin byte.
    task automatic test_back_to_back();
        set_pacing(0, 0);
        sect_img.delete();
        add_noise(8);
        send_span(0, sect_img.size(), 1'b1, 0);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mdl_match_file    = 8'h00;
        mdl_match_channel = 8'h00;
        mdl_pos           = 0;
        mdl_file          = 8'h00;
        mdl_channel       = 8'h00;
        mdl_coding        = 8'h00;
        mdl_taken         = 1'b0;
        foreach (mdl_group[i]) mdl_group[i] = 8'h00;
        foreach (mdl_hist[i]) mdl_hist[i] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_decode_group();
        test_rejects();
        test_restart();
        test_back_to_back();

        if (pending_words.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", pending_words.size()));

        $display("Sent %0d sector bytes, checked %0d words in %0d groups and %0d full sectors.",
                 bytes_sent, words_seen, groups_seen, sectors_seen);
        $display("Covered a clamping stereo group under a long output hold, rejects and restarts.");
        if (error_count == 0) begin
            $display("xa_adpcm_sector_decoder_top verification clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("xa_adpcm_sector_decoder_top verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("xa_adpcm_sector_decoder_top verification failed");
        $finish;
    end

endmodule
